>>> rtl/mwtga_pkg.sv
// shared types and constants for the mixed-width text glyph addresser
// no dependencies; imported by mwtga_hz_addr and the top level
package mwtga_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ZONE_GAP_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLOR    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HANZI_COLOR   = 2'd2;
    localparam int CFG_DATA_W = 4;

    // byte classes
    localparam logic [7:0] HZ_BASE   = 8'd160;
    localparam logic [7:0] ASCII_MAX = 8'd127;
    localparam logic [7:0] NUL_BYTE  = 8'd0;

    // gb2312 zone and position limits
    localparam logic [6:0] ZONE_MAX     = 7'd87;
    localparam logic [6:0] POS_MAX      = 7'd94;
    localparam logic [6:0] GAP_ZONE_LO  = 7'd10;
    localparam logic [6:0] GAP_ZONE_HI  = 7'd15;
    localparam logic [6:0] GAP_ZONES    = 7'd6;

    // glyph index = (zone - 1) * 94 + (position - 1), then scaled by 32 bytes per glyph
    localparam int GLYPH_IDX_W = 13;
    localparam logic [GLYPH_IDX_W-1:0] ZONE_GLYPHS = 13'd94;
    localparam int HZ_GLYPH_SHIFT = 5;
    localparam int ASCII_SHIFT    = 4;
    localparam int OFFSET_W       = 18;

    // pen advance
    localparam logic [15:0] ASCII_ADVANCE = 16'd8;
    localparam logic [15:0] HZ_ADVANCE    = 16'd16;

    // glyph kinds
    localparam logic KIND_ASCII = 1'b0;
    localparam logic KIND_HZ    = 1'b1;

    // one result request
    typedef struct packed {
        logic                draw;
        logic                glyph_kind;
        logic [OFFSET_W-1:0] font_offset;
        logic [15:0]         pos_x;
        logic [15:0]         pos_y;
        logic [3:0]          glyph_color;
        logic                string_done;
    } result_t;

endpackage

>>> rtl/mwtga_hz_addr.sv
// gb2312 zone/position check and 16x16 font offset
// depends on mwtga_pkg; lead and trail bytes are both known to be 160 or more
module mwtga_hz_addr
    import mwtga_pkg::*;
(
    input  logic [7:0]          lead_byte,
    input  logic [7:0]          trail_byte,
    input  logic                zone_gap_mode,
    output logic                glyph_ok,
    output logic [OFFSET_W-1:0] font_offset
);

    logic [7:0]             qh_full;
    logic [7:0]             wz_full;
    logic [6:0]             qh;
    logic [6:0]             wz;
    logic [6:0]             qh_adj;
    logic                   in_gap;
    logic [GLYPH_IDX_W-1:0] glyph_idx;

    // zone and position relative to the gb2312 base
    assign qh_full = lead_byte - HZ_BASE;
    assign wz_full = trail_byte - HZ_BASE;
    assign qh      = qh_full[6:0];
    assign wz      = wz_full[6:0];

    // zones 10..15 are empty in the font; rejected unless gap mode remaps
    assign in_gap = (qh >= GAP_ZONE_LO) && (qh <= GAP_ZONE_HI);

    assign glyph_ok = (qh != 7'd0) && (wz != 7'd0) && (qh <= ZONE_MAX) &&
                      (wz <= POS_MAX) && !(!zone_gap_mode && in_gap);

    // zones above 9 close the gap
    assign qh_adj = (qh >= GAP_ZONE_LO) ? (qh - GAP_ZONES) : qh;

    // glyph index into the 16x16 store
    assign glyph_idx = GLYPH_IDX_W'(qh_adj - 7'd1) * ZONE_GLYPHS +
                       GLYPH_IDX_W'(wz - 7'd1);

    assign font_offset = glyph_ok ? {glyph_idx, {HZ_GLYPH_SHIFT{1'b0}}}
                                  : '0;

endmodule

>>> rtl/mixed_width_text_glyph_addresser_top.sv
// mixed-width text glyph addresser: pen tracking, ascii and gb2312 offsets
// depends on mwtga_pkg and mwtga_hz_addr
// an accepted byte's result goes to the output register, or to the skid register while the output register is held
// throughput: one byte per cycle while in_stall is low; a skid register holds one result under output stall
// the input stalls only while the skid register is full
// reset: pen and line 0, no lead byte pending, halted until new_string; colors 15
module mixed_width_text_glyph_addresser_top
    import mwtga_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // input channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            text_byte,
    input  logic                  new_string,
    input  logic [15:0]           start_x,
    input  logic [15:0]           start_y,
    // output channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  draw,
    output logic                  glyph_kind,
    output logic [OFFSET_W-1:0]   font_offset,
    output logic [15:0]           pos_x,
    output logic [15:0]           pos_y,
    output logic [3:0]            glyph_color,
    output logic                  string_done
);

    // configuration registers
    logic       zone_gap_mode_reg;
    logic [3:0] text_color_reg;
    logic [3:0] hanzi_color_reg;

    // string state
    logic [15:0] pen_x_reg, pen_x_next;
    logic [15:0] line_y_reg, line_y_next;
    logic [7:0]  lead_byte_reg, lead_byte_next;
    logic        lead_pending_reg, lead_pending_next;
    logic        halted_reg, halted_next;

    // output and skid registers
    logic    out_valid_reg;
    result_t out_res_reg;
    logic    skid_valid_reg;
    result_t skid_res_reg;

    logic        in_accept;
    logic        out_take;
    logic        res_valid;
    result_t     res;
    logic [15:0] cur_pen;
    logic [15:0] cur_line;
    logic        cur_pending;
    logic        cur_halted;
    logic        hz_ok;
    logic [OFFSET_W-1:0] hz_offset;

    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_gap_mode_reg <= 1'b0;
            text_color_reg    <= 4'd15;
            hanzi_color_reg   <= 4'd15;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_ZONE_GAP_MODE: zone_gap_mode_reg <= cfg_data[0];
                CFG_TEXT_COLOR:    text_color_reg    <= cfg_data;
                CFG_HANZI_COLOR:   hanzi_color_reg   <= cfg_data;
                default:           ;
            endcase
        end
    end

    // gb2312 pair decode
    mwtga_hz_addr u_hz_addr (
        .lead_byte     (lead_byte_reg),
        .trail_byte    (text_byte),
        .zone_gap_mode (zone_gap_mode_reg),
        .glyph_ok      (hz_ok),
        .font_offset   (hz_offset)
    );

    // effective state after an optional new_string load
    assign cur_pen     = new_string ? start_x : pen_x_reg;
    assign cur_line    = new_string ? start_y : line_y_reg;
    assign cur_pending = new_string ? 1'b0 : lead_pending_reg;
    assign cur_halted  = new_string ? 1'b0 : halted_reg;

    // byte classification, result and next state
    always_comb
    begin
        pen_x_next        = cur_pen;
        line_y_next       = cur_line;
        lead_byte_next    = lead_byte_reg;
        lead_pending_next = cur_pending;
        halted_next       = cur_halted;
        res_valid         = 1'b0;
        res               = '0;

        if (!cur_halted)
        begin
            if (cur_pending)
            begin
                lead_pending_next = 1'b0;
                res_valid         = 1'b1;
                if (text_byte < HZ_BASE)
                begin
                    // bad trail byte ends the string
                    halted_next     = 1'b1;
                    res.string_done = 1'b1;
                end
                else
                begin
                    res.draw        = hz_ok;
                    res.glyph_kind  = KIND_HZ;
                    res.font_offset = hz_offset;
                    res.pos_x       = cur_pen;
                    res.pos_y       = cur_line;
                    res.glyph_color = hanzi_color_reg;
                    pen_x_next      = cur_pen + HZ_ADVANCE;
                end
            end
            else if (text_byte == NUL_BYTE)
            begin
                halted_next     = 1'b1;
                res_valid       = 1'b1;
                res.string_done = 1'b1;
            end
            else if (text_byte < HZ_BASE)
            begin
                // single-byte cell, codes above 127 draw nothing
                res_valid       = 1'b1;
                res.draw        = (text_byte <= ASCII_MAX);
                res.glyph_kind  = KIND_ASCII;
                res.font_offset = (text_byte <= ASCII_MAX)
                                  ? {7'd0, text_byte[6:0], {ASCII_SHIFT{1'b0}}}
                                  : '0;
                res.pos_x       = cur_pen;
                res.pos_y       = cur_line + 16'd1;
                res.glyph_color = text_color_reg;
                pen_x_next      = cur_pen + ASCII_ADVANCE;
            end
            else
            begin
                // lead byte waits for its trail
                lead_byte_next    = text_byte;
                lead_pending_next = 1'b1;
            end
        end
    end

    // string state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_x_reg        <= '0;
            line_y_reg       <= '0;
            lead_byte_reg    <= '0;
            lead_pending_reg <= 1'b0;
            halted_reg       <= 1'b1;
        end
        else if (in_accept)
        begin
            pen_x_reg        <= pen_x_next;
            line_y_reg       <= line_y_next;
            lead_byte_reg    <= lead_byte_next;
            lead_pending_reg <= lead_pending_next;
            halted_reg       <= halted_next;
        end
    end

    // output register with skid stage: control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_take)
        begin
            // skid content or a fresh request refills the output register
            out_valid_reg  <= skid_valid_reg || (in_accept && res_valid);
            skid_valid_reg <= 1'b0;
        end
        else if (in_accept && res_valid)
        begin
            if (!out_valid_reg)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
    end

    // output register with skid stage: payload
    always_ff @(posedge clk)
    begin
        if (out_take && skid_valid_reg)
            out_res_reg <= skid_res_reg;
        else if (in_accept && res_valid && (!out_valid_reg || out_take))
            out_res_reg <= res;
        if (in_accept && res_valid && out_valid_reg && !out_take)
            skid_res_reg <= res;
    end

    assign out_valid   = out_valid_reg;
    assign draw        = out_res_reg.draw;
    assign glyph_kind  = out_res_reg.glyph_kind;
    assign font_offset = out_res_reg.font_offset;
    assign pos_x       = out_res_reg.pos_x;
    assign pos_y       = out_res_reg.pos_y;
    assign glyph_color = out_res_reg.glyph_color;
    assign string_done = out_res_reg.string_done;

`ifndef SYNTHESIS
    // skid stage only fills behind a waiting output request
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full while output register empty");

    // a halted string never holds a pending lead byte
    a_halt_no_lead: assert property (@(posedge clk) disable iff (!rst_n)
        !(halted_reg && lead_pending_reg))
        else $error("lead byte pending while halted");

    // terminating request carries no glyph
    a_done_no_draw: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.string_done) |->
            (!out_res_reg.draw && out_res_reg.font_offset == '0))
        else $error("terminating request marked drawable");

    // a terminating request leaves the block halted
    a_done_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && res_valid && res.string_done) |=> halted_reg)
        else $error("string end did not halt");
`endif

endmodule
